// ----- design/segx_pkg.sv -----
// Shared definitions for the segment intersection pipeline.
// No dependencies.
package segx_pkg;

    // Default coordinate width. Coordinates are signed Q16.8 at this width.
    localparam int COORD_BITS_DEF = 24;

    // Flags that travel with an item through the division cells.
    typedef struct packed {
        logic hit;
        logic negx;   // sign of seg1 x direction
        logic negy;   // sign of seg1 y direction
    } ctl_t;

endpackage

// ----- design/segx_front.sv -----
// Front end: direction vectors, cross products, sign normalization and hit test.
// Depends on segx_pkg.
module segx_front #(
    parameter int COORD_BITS = segx_pkg::COORD_BITS_DEF,
    localparam int DW = COORD_BITS + 1,
    localparam int MW = COORD_BITS + 1,
    localparam int NW = 2 * COORD_BITS + 2
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [COORD_BITS-1:0]  seg1_start_x,
    input  logic signed [COORD_BITS-1:0]  seg1_start_y,
    input  logic signed [COORD_BITS-1:0]  seg1_end_x,
    input  logic signed [COORD_BITS-1:0]  seg1_end_y,
    input  logic signed [COORD_BITS-1:0]  seg2_start_x,
    input  logic signed [COORD_BITS-1:0]  seg2_start_y,
    input  logic signed [COORD_BITS-1:0]  seg2_end_x,
    input  logic signed [COORD_BITS-1:0]  seg2_end_y,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [NW-1:0]                 tn,
    output logic [NW-1:0]                 den,
    output logic signed [COORD_BITS-1:0]  ax,
    output logic signed [COORD_BITS-1:0]  ay,
    output logic [MW-1:0]                 magx,
    output logic [MW-1:0]                 magy,
    output segx_pkg::ctl_t                ctl
);
    import segx_pkg::*;

    localparam int PW = 2 * DW;
    localparam int SW = PW + 1;

    // stage valids
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic en1, en2, en3, en4;

    // stage 1: differences
    logic signed [DW-1:0] d1x_reg, d1y_reg, d2x_reg, d2y_reg, ox_reg, oy_reg;
    logic signed [COORD_BITS-1:0] ax1_reg, ay1_reg;
    // stage 2: products
    logic signed [PW-1:0] pa_reg, pb_reg, pc_reg, pd_reg, pe_reg, pf_reg;
    logic signed [DW-1:0] d1x2_reg, d1y2_reg;
    logic signed [COORD_BITS-1:0] ax2_reg, ay2_reg;
    // stage 3: sums
    logic signed [SW-1:0] den3_reg, un3_reg, tn3_reg;
    logic signed [DW-1:0] d1x3_reg, d1y3_reg;
    logic signed [COORD_BITS-1:0] ax3_reg, ay3_reg;
    // stage 4: normalized
    logic [NW-1:0] tn4_reg, den4_reg;
    logic signed [COORD_BITS-1:0] ax4_reg, ay4_reg;
    logic [MW-1:0] magx4_reg, magy4_reg;
    ctl_t ctl4_reg;

    logic signed [SW-1:0] den_abs, un_n, tn_n;
    logic signed [DW-1:0] d1x_abs, d1y_abs;
    logic neg, hit_c;

    assign en4 = !v4_reg || out_ready;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign in_ready = en1;

    always_comb
    begin
        neg     = den3_reg[SW-1];
        den_abs = neg ? -den3_reg : den3_reg;
        un_n    = neg ? -un3_reg : un3_reg;
        tn_n    = neg ? -tn3_reg : tn3_reg;
        hit_c   = (den_abs != '0) && !un_n[SW-1] && (un_n <= den_abs)
                  && !tn_n[SW-1] && (tn_n <= den_abs);
        d1x_abs = d1x3_reg[DW-1] ? -d1x3_reg : d1x3_reg;
        d1y_abs = d1y3_reg[DW-1] ? -d1y3_reg : d1y3_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= in_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            d1x_reg <= DW'(seg1_end_x) - DW'(seg1_start_x);
            d1y_reg <= DW'(seg1_end_y) - DW'(seg1_start_y);
            d2x_reg <= DW'(seg2_end_x) - DW'(seg2_start_x);
            d2y_reg <= DW'(seg2_end_y) - DW'(seg2_start_y);
            ox_reg  <= DW'(seg1_start_x) - DW'(seg2_start_x);
            oy_reg  <= DW'(seg1_start_y) - DW'(seg2_start_y);
            ax1_reg <= seg1_start_x;
            ay1_reg <= seg1_start_y;
        end
        if (en2)
        begin
            pa_reg   <= d1x_reg * d2y_reg;
            pb_reg   <= d2x_reg * d1y_reg;
            pc_reg   <= d1x_reg * oy_reg;
            pd_reg   <= d1y_reg * ox_reg;
            pe_reg   <= d2x_reg * oy_reg;
            pf_reg   <= d2y_reg * ox_reg;
            d1x2_reg <= d1x_reg;
            d1y2_reg <= d1y_reg;
            ax2_reg  <= ax1_reg;
            ay2_reg  <= ay1_reg;
        end
        if (en3)
        begin
            den3_reg <= SW'(pa_reg) - SW'(pb_reg);
            un3_reg  <= SW'(pc_reg) - SW'(pd_reg);
            tn3_reg  <= SW'(pe_reg) - SW'(pf_reg);
            d1x3_reg <= d1x2_reg;
            d1y3_reg <= d1y2_reg;
            ax3_reg  <= ax2_reg;
            ay3_reg  <= ay2_reg;
        end
        if (en4)
        begin
            tn4_reg       <= tn_n[NW-1:0];
            den4_reg      <= den_abs[NW-1:0];
            ax4_reg       <= ax3_reg;
            ay4_reg       <= ay3_reg;
            magx4_reg     <= MW'(d1x_abs);
            magy4_reg     <= MW'(d1y_abs);
            ctl4_reg.hit  <= hit_c;
            ctl4_reg.negx <= d1x3_reg[DW-1];
            ctl4_reg.negy <= d1y3_reg[DW-1];
        end
    end

    assign out_valid = v4_reg;
    assign tn   = tn4_reg;
    assign den  = den4_reg;
    assign ax   = ax4_reg;
    assign ay   = ay4_reg;
    assign magx = magx4_reg;
    assign magy = magy4_reg;
    assign ctl  = ctl4_reg;

endmodule

// ----- design/segx_cell.sv -----
// One division cell: folds one bit of |d1| into tn*|d1|/den for x and y.
// Depends on segx_pkg.
module segx_cell #(
    parameter int COORD_BITS = segx_pkg::COORD_BITS_DEF,
    parameter int BIT_POS = 0,
    localparam int MW = COORD_BITS + 1,
    localparam int NW = 2 * COORD_BITS + 2
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [NW-1:0]                 in_tn,
    input  logic [NW-1:0]                 in_den,
    input  logic signed [COORD_BITS-1:0]  in_ax,
    input  logic signed [COORD_BITS-1:0]  in_ay,
    input  logic [MW-1:0]                 in_magx,
    input  logic [MW-1:0]                 in_magy,
    input  segx_pkg::ctl_t                in_ctl,
    input  logic [MW-1:0]                 in_qx,
    input  logic [MW-1:0]                 in_qy,
    input  logic [NW-1:0]                 in_rx,
    input  logic [NW-1:0]                 in_ry,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [NW-1:0]                 out_tn,
    output logic [NW-1:0]                 out_den,
    output logic signed [COORD_BITS-1:0]  out_ax,
    output logic signed [COORD_BITS-1:0]  out_ay,
    output logic [MW-1:0]                 out_magx,
    output logic [MW-1:0]                 out_magy,
    output segx_pkg::ctl_t                out_ctl,
    output logic [MW-1:0]                 out_qx,
    output logic [MW-1:0]                 out_qy,
    output logic [NW-1:0]                 out_rx,
    output logic [NW-1:0]                 out_ry
);
    import segx_pkg::*;

    localparam int EW = NW + 2;

    logic valid_reg, en;
    logic [NW-1:0] tn_reg, den_reg, rx_reg, ry_reg;
    logic signed [COORD_BITS-1:0] ax_reg, ay_reg;
    logic [MW-1:0] magx_reg, magy_reg, qx_reg, qy_reg;
    ctl_t ctl_reg;

    logic [EW-1:0] sx, sy, d1, d2;
    logic [NW-1:0] rx_next, ry_next;
    logic [MW-1:0] qx_next, qy_next;

    assign en       = !valid_reg || out_ready;
    assign in_ready = en;

    // r stays below den and tn <= den, so 2r + tn < 3 den: quotient digit 0..2
    always_comb
    begin
        d1 = EW'(in_den);
        d2 = EW'({in_den, 1'b0});
        sx = EW'({in_rx, 1'b0}) + (in_magx[BIT_POS] ? EW'(in_tn) : '0);
        sy = EW'({in_ry, 1'b0}) + (in_magy[BIT_POS] ? EW'(in_tn) : '0);
        if (sx >= d2)
        begin
            rx_next = NW'(sx - d2);
            qx_next = {in_qx[MW-2:0], 1'b0} + MW'(2);
        end
        else if (sx >= d1)
        begin
            rx_next = NW'(sx - d1);
            qx_next = {in_qx[MW-2:0], 1'b0} + MW'(1);
        end
        else
        begin
            rx_next = NW'(sx);
            qx_next = {in_qx[MW-2:0], 1'b0};
        end
        if (sy >= d2)
        begin
            ry_next = NW'(sy - d2);
            qy_next = {in_qy[MW-2:0], 1'b0} + MW'(2);
        end
        else if (sy >= d1)
        begin
            ry_next = NW'(sy - d1);
            qy_next = {in_qy[MW-2:0], 1'b0} + MW'(1);
        end
        else
        begin
            ry_next = NW'(sy);
            qy_next = {in_qy[MW-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tn_reg   <= in_tn;
            den_reg  <= in_den;
            ax_reg   <= in_ax;
            ay_reg   <= in_ay;
            magx_reg <= in_magx;
            magy_reg <= in_magy;
            ctl_reg  <= in_ctl;
            qx_reg   <= qx_next;
            qy_reg   <= qy_next;
            rx_reg   <= rx_next;
            ry_reg   <= ry_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_tn    = tn_reg;
    assign out_den   = den_reg;
    assign out_ax    = ax_reg;
    assign out_ay    = ay_reg;
    assign out_magx  = magx_reg;
    assign out_magy  = magy_reg;
    assign out_ctl   = ctl_reg;
    assign out_qx    = qx_reg;
    assign out_qy    = qy_reg;
    assign out_rx    = rx_reg;
    assign out_ry    = ry_reg;

endmodule

// ----- design/segment_intersection.sv -----
// Segment intersection test with point, fully pipelined: one segment pair
// may enter every clock and one result leaves every clock while out_ready
// is high. It has four front-end stages (differences, 25x25 cross
// products, sums and sign normalization), COORD_BITS + 1 division cells
// and one output register. Each stage holds its own transfer, so
// bubbles collapse and input keeps flowing while a result waits at the
// output. Coordinates are signed fixed point; the binary point position
// does not enter the math, so Q16.8 and any other split behave the same.
// Depends on segx_pkg, segx_front, segx_cell.
module segment_intersection #(
    parameter int COORD_BITS = segx_pkg::COORD_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [COORD_BITS-1:0]  seg1_start_x,
    input  logic signed [COORD_BITS-1:0]  seg1_start_y,
    input  logic signed [COORD_BITS-1:0]  seg1_end_x,
    input  logic signed [COORD_BITS-1:0]  seg1_end_y,
    input  logic signed [COORD_BITS-1:0]  seg2_start_x,
    input  logic signed [COORD_BITS-1:0]  seg2_start_y,
    input  logic signed [COORD_BITS-1:0]  seg2_end_x,
    input  logic signed [COORD_BITS-1:0]  seg2_end_y,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          hit,
    output logic signed [COORD_BITS-1:0]  cross_x,
    output logic signed [COORD_BITS-1:0]  cross_y
);
    import segx_pkg::*;

    localparam int MW = COORD_BITS + 1;       // |d1| and quotient width
    localparam int NW = 2 * COORD_BITS + 2;   // |den|, tn, remainder width

    // Link k feeds cell k; link MW is the chain output.
    logic                         lk_valid [MW+1];
    logic                         lk_ready [MW+1];
    logic [NW-1:0]                lk_tn    [MW+1];
    logic [NW-1:0]                lk_den   [MW+1];
    logic signed [COORD_BITS-1:0] lk_ax    [MW+1];
    logic signed [COORD_BITS-1:0] lk_ay    [MW+1];
    logic [MW-1:0]                lk_magx  [MW+1];
    logic [MW-1:0]                lk_magy  [MW+1];
    ctl_t                         lk_ctl   [MW+1];
    logic [MW-1:0]                lk_qx    [MW+1];
    logic [MW-1:0]                lk_qy    [MW+1];
    logic [NW-1:0]                lk_rx    [MW+1];
    logic [NW-1:0]                lk_ry    [MW+1];

    logic                         out_valid_reg, out_en;
    logic                         hit_reg;
    logic signed [COORD_BITS-1:0] cross_x_reg, cross_y_reg;
    logic signed [COORD_BITS-1:0] px_next, py_next;

    segx_front #(.COORD_BITS(COORD_BITS)) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .seg1_start_x (seg1_start_x),
        .seg1_start_y (seg1_start_y),
        .seg1_end_x   (seg1_end_x),
        .seg1_end_y   (seg1_end_y),
        .seg2_start_x (seg2_start_x),
        .seg2_start_y (seg2_start_y),
        .seg2_end_x   (seg2_end_x),
        .seg2_end_y   (seg2_end_y),
        .out_valid    (lk_valid[0]),
        .out_ready    (lk_ready[0]),
        .tn           (lk_tn[0]),
        .den          (lk_den[0]),
        .ax           (lk_ax[0]),
        .ay           (lk_ay[0]),
        .magx         (lk_magx[0]),
        .magy         (lk_magy[0]),
        .ctl          (lk_ctl[0])
    );

    // Quotient and remainder start at zero.
    assign lk_qx[0] = '0;
    assign lk_qy[0] = '0;
    assign lk_rx[0] = '0;
    assign lk_ry[0] = '0;

    // Cell k handles bit MW-1-k of |d1|, most significant first.
    for (genvar k = 0; k < MW; k++)
    begin : g_cell
        segx_cell #(.COORD_BITS(COORD_BITS), .BIT_POS(MW - 1 - k)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (lk_valid[k]),
            .in_ready  (lk_ready[k]),
            .in_tn     (lk_tn[k]),
            .in_den    (lk_den[k]),
            .in_ax     (lk_ax[k]),
            .in_ay     (lk_ay[k]),
            .in_magx   (lk_magx[k]),
            .in_magy   (lk_magy[k]),
            .in_ctl    (lk_ctl[k]),
            .in_qx     (lk_qx[k]),
            .in_qy     (lk_qy[k]),
            .in_rx     (lk_rx[k]),
            .in_ry     (lk_ry[k]),
            .out_valid (lk_valid[k+1]),
            .out_ready (lk_ready[k+1]),
            .out_tn    (lk_tn[k+1]),
            .out_den   (lk_den[k+1]),
            .out_ax    (lk_ax[k+1]),
            .out_ay    (lk_ay[k+1]),
            .out_magx  (lk_magx[k+1]),
            .out_magy  (lk_magy[k+1]),
            .out_ctl   (lk_ctl[k+1]),
            .out_qx    (lk_qx[k+1]),
            .out_qy    (lk_qy[k+1]),
            .out_rx    (lk_rx[k+1]),
            .out_ry    (lk_ry[k+1])
        );
    end

    // Output register: start point plus signed truncated offset; zero on a miss.
    assign out_en        = !out_valid_reg || out_ready;
    assign lk_ready[MW]  = out_en;

    always_comb
    begin
        px_next = lk_ax[MW] + (lk_ctl[MW].negx ? -COORD_BITS'(lk_qx[MW])
                                                : COORD_BITS'(lk_qx[MW]));
        py_next = lk_ay[MW] + (lk_ctl[MW].negy ? -COORD_BITS'(lk_qy[MW])
                                                : COORD_BITS'(lk_qy[MW]));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_en)
            out_valid_reg <= lk_valid[MW];
    end

    always_ff @(posedge clk)
    begin
        if (out_en)
        begin
            hit_reg     <= lk_ctl[MW].hit;
            cross_x_reg <= lk_ctl[MW].hit ? px_next : '0;
            cross_y_reg <= lk_ctl[MW].hit ? py_next : '0;
        end
    end

    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;
    assign cross_x   = cross_x_reg;
    assign cross_y   = cross_y_reg;

endmodule
